>>> hdl/necled_pkg.sv
package necled_pkg;

	localparam int FRAME_BITS = 32;
	localparam int BIDX_W     = $clog2(FRAME_BITS + 1);
	localparam int TICK_W     = 16;
	localparam int KEY_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP = 3'd5;

	localparam logic [CFG_DATA_W-1:0] RST_LEADER_MIN = 16'd13500;
	localparam logic [CFG_DATA_W-1:0] RST_LEADER_MAX = 16'd14500;
	localparam logic [CFG_DATA_W-1:0] RST_ONE_MIN    = 16'd2250;
	localparam logic [CFG_DATA_W-1:0] RST_ONE_MAX    = 16'd2450;
	localparam logic [CFG_DATA_W-1:0] RST_PWM_FULL   = 16'd10000;
	localparam logic [CFG_DATA_W-1:0] RST_LEVEL_STEP = 16'd2000;

	// receiver phases
	localparam logic [1:0] PH_WAIT_FALL = 2'd0;
	localparam logic [1:0] PH_LEADER    = 2'd1;
	localparam logic [1:0] PH_SKIP      = 2'd2;
	localparam logic [1:0] PH_COLLECT   = 2'd3;

	localparam logic [KEY_W-1:0] KEY_RED_ON         = 16'hBA45;
	localparam logic [KEY_W-1:0] KEY_RED_OFF        = 16'hB946;
	localparam logic [KEY_W-1:0] KEY_RED_TOGGLE     = 16'hB847;
	localparam logic [KEY_W-1:0] KEY_GREEN_ON       = 16'hBB44;
	localparam logic [KEY_W-1:0] KEY_GREEN_OFF      = 16'hBF40;
	localparam logic [KEY_W-1:0] KEY_GREEN_TOGGLE_A = 16'hBC43;
	localparam logic [KEY_W-1:0] KEY_GREEN_DOWN     = 16'hF807;
	localparam logic [KEY_W-1:0] KEY_GREEN_TOGGLE_B = 16'hEA15;
	localparam logic [KEY_W-1:0] KEY_GREEN_UP       = 16'hF609;

	typedef struct packed {
		logic                  red_on;
		logic                  green_on;
		logic [TICK_W-1:0]     green_level;
		logic [TICK_W-1:0]     green_drive;
	} led_state_t;

	typedef struct packed {
		logic [TICK_W-1:0] pwm_full;
		logic [TICK_W-1:0] level_step;
	} pwm_cfg_t;

endpackage

>>> hdl/necled_if.sv
interface necled_in_if;
	logic                               valid;
	logic                               ready;
	logic                               edge_rising;
	logic [necled_pkg::TICK_W-1:0]      interval_ticks;

	modport source (output valid, output edge_rising, output interval_ticks, input ready);
	modport sink   (input valid, input edge_rising, input interval_ticks, output ready);
endinterface

interface necled_out_if;
	logic                               valid;
	logic                               ready;
	logic [necled_pkg::KEY_W-1:0]       command_key;
	logic                               red_led;
	logic [necled_pkg::TICK_W-1:0]      green_compare;
	logic                               green_enabled;
	logic [necled_pkg::TICK_W-1:0]      green_level;
	logic                               replayed;

	modport source (output valid, output command_key, output red_led, output green_compare,
		output green_enabled, output green_level, output replayed, input ready);
	modport sink   (input valid, input command_key, input red_led, input green_compare,
		input green_enabled, input green_level, input replayed, output ready);
endinterface

>>> hdl/necled_key_exec.sv
module necled_key_exec (
	input  logic [necled_pkg::KEY_W-1:0] key,
	input  necled_pkg::pwm_cfg_t         pwm,
	input  necled_pkg::led_state_t       cur,
	output necled_pkg::led_state_t       nxt
);
	import necled_pkg::*;

	logic [TICK_W:0]   up_sum;
	logic [TICK_W-1:0] up_level;
	logic [TICK_W-1:0] down_level;

	assign up_sum     = {1'b0, cur.green_level} + {1'b0, pwm.level_step};
	assign up_level   = (up_sum > {1'b0, pwm.pwm_full}) ? pwm.pwm_full : up_sum[TICK_W-1:0];
	assign down_level = (cur.green_level > pwm.level_step) ?
		(cur.green_level - pwm.level_step) : '0;

	always_comb begin
		nxt = cur;
		unique case (key)
			KEY_RED_ON:     nxt.red_on = 1'b1;
			KEY_RED_OFF:    nxt.red_on = 1'b0;
			KEY_RED_TOGGLE: nxt.red_on = ~cur.red_on;
			KEY_GREEN_ON: begin
				nxt.green_on    = 1'b1;
				nxt.green_level = pwm.pwm_full;
				nxt.green_drive = pwm.pwm_full;
			end
			KEY_GREEN_OFF: begin
				nxt.green_on    = 1'b0;
				nxt.green_drive = '0;
			end
			KEY_GREEN_TOGGLE_A, KEY_GREEN_TOGGLE_B: begin
				nxt.green_on    = ~cur.green_on;
				nxt.green_drive = cur.green_on ? '0 : cur.green_level;
			end
			KEY_GREEN_DOWN: begin
				nxt.green_level = down_level;
				if (cur.green_on) begin
					nxt.green_drive = down_level;
				end
			end
			KEY_GREEN_UP: begin
				nxt.green_level = up_level;
				if (cur.green_on) begin
					nxt.green_drive = up_level;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/nec_ir_remote_led_controller_core.sv
// Channel   Dir  Payload                                              Handshake
// ir_in     in   edge_rising, interval_ticks                          valid/ready
// key_out   out  command_key, red_led, green_compare, green_enabled,  valid/ready
//                green_level, replayed
// cfg       in   cfg_index, cfg_wdata                                 cfg_we
// Every accepted edge item is held in the input register, where the
// receiver phase, tick sum and LED state update; a result lands in the output
// register as the item leaves. One item per cycle sustained; the input stage only
// holds when it has a result and the output register is full and not taken.
// arst_n clears control state and restores the register reset values.
module nec_ir_remote_led_controller_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [necled_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [necled_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	necled_in_if.sink                            ir_in,
	necled_out_if.source                         key_out
);
	import necled_pkg::*;

	logic [TICK_W-1:0] leader_min_q, leader_max_q, one_min_q, one_max_q;
	pwm_cfg_t          pwm_q;

	logic              valid_s1;
	logic              rising_s1;
	logic [TICK_W-1:0] ticks_s1;

	logic [1:0]        phase_q, phase_nxt;
	logic [TICK_W-1:0] sum_q, sum_nxt;
	logic [BIDX_W-1:0] bidx_q, bidx_nxt, bidx_inc;
	logic [KEY_W-1:0]  key_q, key_nxt;
	led_state_t        led_q, led_nxt;

	logic [TICK_W:0]   sum_wide;
	logic [TICK_W-1:0] ticks;
	logic              lead_ok, one_ok;
	logic              emit, replay, adv_s1;

	logic              out_valid_q;
	logic [KEY_W-1:0]  out_key_q;
	led_state_t        out_led_q;
	logic              out_replay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_min_q     <= RST_LEADER_MIN;
			leader_max_q     <= RST_LEADER_MAX;
			one_min_q        <= RST_ONE_MIN;
			one_max_q        <= RST_ONE_MAX;
			pwm_q.pwm_full   <= RST_PWM_FULL;
			pwm_q.level_step <= RST_LEVEL_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEADER_MIN: leader_min_q     <= cfg_wdata;
				CFG_LEADER_MAX: leader_max_q     <= cfg_wdata;
				CFG_ONE_MIN:    one_min_q        <= cfg_wdata;
				CFG_ONE_MAX:    one_max_q        <= cfg_wdata;
				CFG_PWM_FULL:   pwm_q.pwm_full   <= cfg_wdata;
				CFG_LEVEL_STEP: pwm_q.level_step <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ir_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ir_in.ready) begin
			valid_s1 <= ir_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ir_in.valid && ir_in.ready) begin
			rising_s1 <= ir_in.edge_rising;
			ticks_s1  <= ir_in.interval_ticks;
		end
	end

	// saturating tick sum since the last edge that counted
	assign sum_wide = {1'b0, sum_q} + {1'b0, ticks_s1};
	assign ticks    = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
	assign lead_ok  = (ticks > leader_min_q) && (ticks < leader_max_q);
	assign one_ok   = (ticks > one_min_q) && (ticks < one_max_q);
	assign bidx_inc = bidx_q + BIDX_W'(1);

	always_comb begin
		phase_nxt = phase_q;
		sum_nxt   = ticks;
		bidx_nxt  = bidx_q;
		key_nxt   = key_q;
		emit      = 1'b0;
		replay    = 1'b0;
		unique case (phase_q)
			PH_WAIT_FALL: begin
				if (!rising_s1) begin
					sum_nxt   = '0;
					phase_nxt = PH_LEADER;
				end
			end
			PH_LEADER: begin
				if (!rising_s1) begin
					sum_nxt = '0;
					if (lead_ok) begin
						phase_nxt = PH_SKIP;
					end else begin
						// bad leader: repeat the last key
						phase_nxt = PH_WAIT_FALL;
						emit      = 1'b1;
						replay    = 1'b1;
					end
				end
			end
			PH_SKIP: begin
				if (rising_s1) begin
					sum_nxt   = '0;
					bidx_nxt  = '0;
					phase_nxt = PH_COLLECT;
				end
			end
			PH_COLLECT: begin
				if (rising_s1) begin
					sum_nxt  = '0;
					key_nxt  = {one_ok, key_q[KEY_W-1:1]};
					bidx_nxt = bidx_inc;
					if (bidx_inc >= BIDX_W'(FRAME_BITS)) begin
						bidx_nxt  = '0;
						phase_nxt = PH_WAIT_FALL;
						emit      = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	necled_key_exec u_key_exec (
		.key (key_nxt),
		.pwm (pwm_q),
		.cur (led_q),
		.nxt (led_nxt)
	);

	assign adv_s1 = !emit || !out_valid_q || key_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_WAIT_FALL;
			sum_q             <= '0;
			bidx_q            <= '0;
			key_q             <= '0;
			led_q.red_on      <= 1'b0;
			led_q.green_on    <= 1'b1;
			led_q.green_level <= RST_PWM_FULL;
			led_q.green_drive <= RST_PWM_FULL;
		end else if (valid_s1 && adv_s1) begin
			phase_q <= phase_nxt;
			sum_q   <= sum_nxt;
			bidx_q  <= bidx_nxt;
			key_q   <= key_nxt;
			if (emit) begin
				led_q <= led_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (key_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && emit) begin
			out_key_q    <= key_nxt;
			out_led_q    <= led_nxt;
			out_replay_q <= replay;
		end
	end

	assign key_out.valid         = out_valid_q;
	assign key_out.command_key   = out_key_q;
	assign key_out.red_led       = out_led_q.red_on;
	assign key_out.green_compare = out_led_q.green_drive;
	assign key_out.green_enabled = out_led_q.green_on;
	assign key_out.green_level   = out_led_q.green_level;
	assign key_out.replayed      = out_replay_q;

`ifndef SYNTHESIS
	a_bidx_only_collect: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_COLLECT) |-> (bidx_q == '0))
		else $error("bit index nonzero outside bit collection");

	a_bidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bidx_q < BIDX_W'(FRAME_BITS))
		else $error("bit index past frame length");

	a_drive_needs_on: assert property (@(posedge clk) disable iff (!arst_n)
		(led_q.green_drive != '0) |-> led_q.green_on)
		else $error("green driven while disabled");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |-> $past(valid_s1 && emit))
		else $error("result without a decoded item");
`endif

endmodule
